### rtl/wtom_pkg.sv
// Shared types and constants of the winding thermal overload model.
// Holds the input and result word layouts, table entry type and code names.
// No dependencies; the block refers to it by scoped names and the testbench imports it.
package wtom_pkg;

	// Default depth of the overload table
	localparam int MAX_POINTS_DEF = 8;

	// ln(2) in Q32, used by the exponential series
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// One in Q32 (33 bits wide)
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	// Index of the last series term evaluated after the linear one
	localparam logic [3:0] SERIES_LAST = 4'd14;

	// Input word modes
	localparam logic [1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [1:0] MODE_CYCLE   = 2'd1;
	localparam logic [1:0] MODE_TABLE   = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_NOMINAL = 2'd0;
	localparam logic [1:0] CFG_COOLING = 2'd1;
	localparam logic [1:0] CFG_POINTS  = 2'd2;
	localparam logic [1:0] CFG_PERIOD  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] sample_current;
		logic [2:0]         point_index;
		logic [15:0]        point_current;
		logic [15:0]        point_time;
	} in_word_t;

	typedef struct packed {
		logic [15:0] current_limit;
		logic [15:0] heat_level;
		logic [15:0] average_current;
		logic        cycle_done;
	} out_word_t;

	// One overload table point
	typedef struct packed {
		logic [15:0] cur;
		logic [15:0] tim;
	} pt_entry_t;

endpackage

### rtl/winding_thermal_overload_model.sv
// Winding thermal overload model: sample accumulation, thermal integrator, current limit.
// Uses wtom_pkg for word layouts, table entry type, mode and register codes.
// Contains the sequencer, the shared multiplier, the shared divider and the table memory.

// Sample, table-write and restart words are accepted in the idle state; their result word
// is loaded in the finish state once the output register is free. A cycle-end word runs
// the whole thermal update on one shared 33x33 multiplier and one restoring divider that
// retires one quotient bit per cycle; most of the work goes to the two coefficient
// evaluations, each with two 28-step base-2 logarithms (each step squaring on the
// multiplier) and thirteen 32-bit series divisions. Degenerate tables skip the logarithms
// and series. The block accepts no word while a cycle-end word is in progress; a finished
// result waits in the output register and does not hold off the next word.
module winding_thermal_overload_model #(
	parameter int MAX_POINTS = wtom_pkg::MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wtom_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wtom_pkg::out_word_t  out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	typedef enum logic [30:0] {
		ST_IDLE     = 31'd1 << 0,
		ST_AVG      = 31'd1 << 1,
		ST_AVG_DONE = 31'd1 << 2,
		ST_SETUP    = 31'd1 << 3,
		ST_SRCH_RD  = 31'd1 << 4,
		ST_SRCH_CHK = 31'd1 << 5,
		ST_INT_DIV  = 31'd1 << 6,
		ST_INT_FIN  = 31'd1 << 7,
		ST_CF_START = 31'd1 << 8,
		ST_LG_INIT  = 31'd1 << 9,
		ST_LG_STEP  = 31'd1 << 10,
		ST_CF_E     = 31'd1 << 11,
		ST_CF_EX    = 31'd1 << 12,
		ST_CF_Y     = 31'd1 << 13,
		ST_CF_T     = 31'd1 << 14,
		ST_CF_S     = 31'd1 << 15,
		ST_CF_K     = 31'd1 << 16,
		ST_AX       = 31'd1 << 17,
		ST_ACC      = 31'd1 << 18,
		ST_FR       = 31'd1 << 19,
		ST_CLAMP    = 31'd1 << 20,
		ST_LM_RD    = 31'd1 << 21,
		ST_LM_CHK   = 31'd1 << 22,
		ST_LM_INV   = 31'd1 << 23,
		ST_LM_INVD  = 31'd1 << 24,
		ST_LM_M1    = 31'd1 << 25,
		ST_LM_M2    = 31'd1 << 26,
		ST_LM_M3    = 31'd1 << 27,
		ST_MUL_WAIT = 31'd1 << 28,
		ST_DIV_RUN  = 31'd1 << 29,
		ST_FIN      = 31'd1 << 30
	} state_t;

	state_t state_q, ret_q, coef_ret_q;

	// Configuration registers
	logic [12:0] nom_q;
	logic [15:0] cool_q;
	logic [3:0]  pcount_q;
	logic [15:0] period_q;

	// Architectural state
	logic [15:0] sum_q, cnt_q, avg_q, lim_q, cur0_q;
	logic [31:0] integ_q;
	logic        done_q;
	logic        out_valid_q;
	wtom_pkg::out_word_t out_q;

	// Table memory
	logic [31:0] mem [MAX_POINTS];
	wtom_pkg::pt_entry_t rdata_q, prev_q;
	logic [NW-1:0] i_q, n_pts, i_nx;

	// Sequencer working registers
	logic               heat_q, dneg_q, lg_phase_q;
	logic signed [16:0] ca_q, cb_q;
	logic [15:0]        ct_q;
	logic [32:0]        ma_q, mb_q;
	logic [65:0]        prod_q;
	logic [47:0]        dq_q;
	logic [32:0]        dv_q, r_q;
	logic [5:0]         dcnt_q;
	logic [31:0]        lres_q, lgb_q, y_q;
	logic [4:0]         lit_q;
	logic [5:0]         ip_q;
	logic [32:0]        s_q, k_q;
	logic [3:0]         tn_q;
	logic [15:0]        ax_q, inv_q;
	logic signed [35:0] acc_q;

	// Combinational helpers
	logic        in_acc;
	logic [15:0] imax, hi, mag;
	logic [16:0] acc17, c10, c10m1, rst_sum;
	logic        acc_ok;
	logic [15:0] capv;
	logic [15:0] lg_v;
	logic [3:0]  lg_msb;
	logic [30:0] lg_m, lg_mn;
	logic [31:0] sq, lg_res_n;
	logic [33:0] rs, rdiff;
	logic        rge;
	logic [24:0] kh;
	logic [25:0] kh1;
	logic [15:0] ax_n, ax_opnd;
	logic signed [35:0] acc_n, acc_fr, bnd_hi, bnd_lo, lim_n, pq_s;
	logic signed [16:0] dt_s, dl_s;
	logic [15:0] dt_mag, dl_mag;
	logic [32:0] ex, s_n;
	logic [31:0] term_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clamp the point count to between one and the table depth
	always_comb begin
		if (pcount_q == 4'd0) begin
			n_pts = NW'(1);
		end else if (32'(pcount_q) > MAX_POINTS) begin
			n_pts = NW'(MAX_POINTS);
		end else begin
			n_pts = NW'(pcount_q);
		end
	end

	assign i_nx = i_q + NW'(1);
	assign imax = cur0_q - 16'd1;
	assign hi   = integ_q[31:16];

	// Sample magnitude and overflow check
	assign mag    = in_data.sample_current[15] ? (16'd0 - in_data.sample_current)
		: in_data.sample_current;
	assign acc17  = {1'b0, sum_q} + {1'b0, mag};
	assign acc_ok = !acc17[16] && (cnt_q != 16'hffff);

	// Limit cap and restart values
	assign c10     = 17'(nom_q) * 17'd10;
	assign c10m1   = c10 - 17'd1;
	assign capv    = (c10 == 17'd0) ? 16'd0 : (c10m1[16] ? 16'hffff : c10m1[15:0]);
	assign rst_sum = {1'b0, cur0_q} + 17'(nom_q);

	// Normalize the logarithm argument
	always_comb begin
		lg_v   = lg_phase_q ? ca_q[15:0] : cb_q[15:0];
		lg_msb = 4'd0;
		for (int b = 0; b < 16; b++) begin
			if (lg_v[b]) begin
				lg_msb = 4'(b);
			end
		end
		lg_m = 31'(lg_v) << (5'd30 - {1'b0, lg_msb});
	end

	// Square step of the logarithm
	assign sq       = prod_q[61:30];
	assign lg_mn    = sq[31] ? sq[31:1] : sq[30:0];
	assign lg_res_n = lres_q | (sq[31] ? (32'd1 << (5'd27 - lit_q)) : 32'd0);

	// Restoring divider step
	assign rs    = {r_q, dq_q[47]};
	assign rge   = rs >= {1'b0, dv_q};
	assign rdiff = rs - {1'b0, dv_q};

	// Series accumulation and final coefficient
	assign term_n = dq_q[31:0];
	assign s_n    = tn_q[0] ? (s_q + {1'b0, term_n}) : (s_q - {1'b0, term_n});
	assign ex     = wtom_pkg::ONE_Q32 - s_q;

	// Integrator gain from the coefficient
	assign kh      = k_q[32:8];
	assign kh1     = {1'b0, kh} + 26'd1;
	assign ax_n    = heat_q ? ((kh1 >= 26'h00ffff) ? 16'hffff : kh1[15:0])
		: ((kh >= 25'h00ffff) ? 16'hffff : kh[15:0]);
	assign ax_opnd = heat_q ? (avg_q - hi) : (hi - avg_q);

	// Integrator arithmetic
	assign acc_n  = heat_q ? ($signed({4'd0, integ_q}) + $signed({12'd0, prod_q[31:8]}))
		: ($signed({4'd0, integ_q}) - $signed({12'd0, prod_q[31:8]}));
	assign acc_fr = acc_q - $signed({28'd0, prod_q[31:24]});
	assign bnd_hi = $signed({4'd0, imax, 16'd0});
	assign bnd_lo = $signed({7'd0, nom_q, 16'd0});

	// Interpolation differences and limit term
	assign dt_s   = $signed({1'b0, rdata_q.tim}) - $signed({1'b0, prev_q.tim});
	assign dt_mag = dt_s[16] ? 16'(17'd0 - dt_s) : dt_s[15:0];
	assign dl_s   = $signed({1'b0, imax}) - $signed({1'b0, hi});
	assign dl_mag = dl_s[16] ? 16'(17'd0 - dl_s) : dl_s[15:0];
	assign pq_s   = $signed({3'd0, prod_q[32:0]});
	assign lim_n  = acc_q - $signed({20'd0, prod_q[31:16]}) + $signed({20'd0, hi});

	// Write and read the overload table
	always_ff @(posedge clk) begin
		if (in_acc && (in_data.mode == wtom_pkg::MODE_TABLE)
				&& (32'(in_data.point_index) < MAX_POINTS)) begin
			mem[AW'(in_data.point_index)] <= {in_data.point_current, in_data.point_time};
		end
		rdata_q <= mem[i_q[AW-1:0]];
	end

	// Run the shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= ma_q * mb_q;
	end

	// Sequence the thermal update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			coef_ret_q  <= ST_IDLE;
			nom_q       <= 13'd100;
			cool_q      <= 16'd600;
			pcount_q    <= 4'd4;
			period_q    <= 16'd1;
			sum_q       <= '0;
			cnt_q       <= '0;
			avg_q       <= '0;
			lim_q       <= '0;
			integ_q     <= '0;
			cur0_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			prev_q      <= '0;
			i_q         <= '0;
			heat_q      <= 1'b0;
			dneg_q      <= 1'b0;
			lg_phase_q  <= 1'b0;
			ca_q        <= '0;
			cb_q        <= '0;
			ct_q        <= '0;
			ma_q        <= '0;
			mb_q        <= '0;
			dq_q        <= '0;
			dv_q        <= '0;
			r_q         <= '0;
			dcnt_q      <= '0;
			lres_q      <= '0;
			lgb_q       <= '0;
			lit_q       <= '0;
			ip_q        <= '0;
			y_q         <= '0;
			s_q         <= '0;
			k_q         <= '0;
			tn_q        <= '0;
			ax_q        <= '0;
			inv_q       <= '0;
			acc_q       <= '0;
		end else begin
			// Take configuration writes
			if (cfg_we) begin
				case (cfg_index)
					wtom_pkg::CFG_NOMINAL: nom_q    <= cfg_data[12:0];
					wtom_pkg::CFG_COOLING: cool_q   <= cfg_data;
					wtom_pkg::CFG_POINTS:  pcount_q <= cfg_data[3:0];
					wtom_pkg::CFG_PERIOD:  period_q <= cfg_data;
					default: ;
				endcase
			end

			// Drop the result word once taken
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						done_q <= 1'b0;
						state_q <= ST_FIN;
						case (in_data.mode)
							wtom_pkg::MODE_TABLE: begin
								if (in_data.point_index == 3'd0) begin
									cur0_q <= in_data.point_current;
								end
							end
							wtom_pkg::MODE_RESTART: begin
								lim_q   <= c10[16] ? 16'hffff : c10[15:0];
								integ_q <= {rst_sum[16:1], 16'd0};
								sum_q   <= '0;
								cnt_q   <= '0;
							end
							wtom_pkg::MODE_CYCLE: begin
								if (acc_ok) begin
									sum_q <= acc17[15:0];
									cnt_q <= cnt_q + 16'd1;
								end
								state_q <= ST_AVG;
							end
							default: begin
								if (acc_ok) begin
									sum_q <= acc17[15:0];
									cnt_q <= cnt_q + 16'd1;
								end
							end
						endcase
					end
				end

				// Start the rounded average
				ST_AVG: begin
					sum_q <= '0;
					cnt_q <= '0;
					if (cnt_q != 16'd0) begin
						dq_q    <= {({1'b0, sum_q} + {2'b0, cnt_q[15:1]}), 31'd0};
						dv_q    <= {17'd0, cnt_q};
						r_q     <= '0;
						dcnt_q  <= 6'd17;
						ret_q   <= ST_AVG_DONE;
						state_q <= ST_DIV_RUN;
					end else begin
						state_q <= ST_SETUP;
					end
				end

				ST_AVG_DONE: begin
					avg_q   <= dq_q[15:0];
					state_q <= ST_SETUP;
				end

				// Choose heating or cooling
				ST_SETUP: begin
					if (avg_q >= hi) begin
						heat_q  <= 1'b1;
						i_q     <= '0;
						state_q <= ST_SRCH_RD;
					end else begin
						heat_q     <= 1'b0;
						ca_q       <= $signed({1'b0, cur0_q}) - $signed({1'b0, imax});
						cb_q       <= $signed({1'b0, cur0_q}) - $signed({4'd0, nom_q});
						ct_q       <= cool_q;
						coef_ret_q <= ST_AX;
						state_q    <= ST_CF_START;
					end
				end

				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CHK;
				end

				// Walk the table to the first point above the average
				ST_SRCH_CHK: begin
					coef_ret_q <= ST_AX;
					if (avg_q >= rdata_q.cur) begin
						prev_q <= rdata_q;
						if (i_nx == n_pts) begin
							ca_q    <= $signed({1'b0, rdata_q.cur}) - $signed({1'b0, imax});
							cb_q    <= $signed({1'b0, rdata_q.cur}) - $signed({4'd0, nom_q});
							ct_q    <= rdata_q.tim;
							state_q <= ST_CF_START;
						end else begin
							i_q     <= i_nx;
							state_q <= ST_SRCH_RD;
						end
					end else if (i_q == '0) begin
						ca_q    <= $signed({1'b0, rdata_q.cur}) - $signed({1'b0, imax});
						cb_q    <= $signed({1'b0, rdata_q.cur}) - $signed({4'd0, nom_q});
						ct_q    <= rdata_q.tim;
						state_q <= ST_CF_START;
					end else begin
						ca_q    <= $signed({1'b0, avg_q}) - $signed({1'b0, imax});
						cb_q    <= $signed({1'b0, avg_q}) - $signed({4'd0, nom_q});
						dneg_q  <= dt_s[16];
						ma_q    <= {17'd0, dt_mag};
						mb_q    <= {17'd0, avg_q - prev_q.cur};
						dv_q    <= {17'd0, rdata_q.cur - prev_q.cur};
						ret_q   <= ST_INT_DIV;
						state_q <= ST_MUL_WAIT;
					end
				end

				ST_INT_DIV: begin
					dq_q    <= {prod_q[31:0], 16'd0};
					r_q     <= '0;
					dcnt_q  <= 6'd32;
					ret_q   <= ST_INT_FIN;
					state_q <= ST_DIV_RUN;
				end

				// Interpolate the permitted time
				ST_INT_FIN: begin
					ct_q    <= dneg_q ? (prev_q.tim - dq_q[15:0]) : (prev_q.tim + dq_q[15:0]);
					state_q <= ST_CF_START;
				end

				// Catch degenerate ratios, else start the logarithms
				ST_CF_START: begin
					if ((cb_q <= 17'sd0) || (ca_q >= cb_q)) begin
						k_q     <= '0;
						state_q <= coef_ret_q;
					end else if ((ca_q <= 17'sd0) || (ct_q == 16'd0)) begin
						k_q     <= wtom_pkg::ONE_Q32;
						state_q <= coef_ret_q;
					end else begin
						lg_phase_q <= 1'b0;
						state_q    <= ST_LG_INIT;
					end
				end

				ST_LG_INIT: begin
					ma_q    <= {2'd0, lg_m};
					mb_q    <= {2'd0, lg_m};
					lres_q  <= {lg_msb, 28'd0};
					lit_q   <= '0;
					ret_q   <= ST_LG_STEP;
					state_q <= ST_MUL_WAIT;
				end

				// Square and shift one fraction bit of the logarithm
				ST_LG_STEP: begin
					lres_q <= lg_res_n;
					lit_q  <= lit_q + 5'd1;
					if (lit_q == 5'd27) begin
						if (!lg_phase_q) begin
							lgb_q      <= lg_res_n;
							lg_phase_q <= 1'b1;
							state_q    <= ST_LG_INIT;
						end else begin
							ma_q    <= {17'd0, period_q};
							mb_q    <= {1'b0, lgb_q - lg_res_n};
							ret_q   <= ST_CF_E;
							state_q <= ST_MUL_WAIT;
						end
					end else begin
						ma_q    <= {2'd0, lg_mn};
						mb_q    <= {2'd0, lg_mn};
						ret_q   <= ST_LG_STEP;
						state_q <= ST_MUL_WAIT;
					end
				end

				ST_CF_E: begin
					dq_q    <= prod_q[47:0];
					dv_q    <= {17'd0, ct_q};
					r_q     <= '0;
					dcnt_q  <= 6'd48;
					ret_q   <= ST_CF_EX;
					state_q <= ST_DIV_RUN;
				end

				// Split the exponent into shift and fraction
				ST_CF_EX: begin
					if (dq_q[47:28] >= 20'd40) begin
						k_q     <= wtom_pkg::ONE_Q32;
						state_q <= coef_ret_q;
					end else begin
						ip_q    <= dq_q[33:28];
						ma_q    <= {5'd0, dq_q[27:0]};
						mb_q    <= {1'b0, wtom_pkg::LN2_Q32};
						ret_q   <= ST_CF_Y;
						state_q <= ST_MUL_WAIT;
					end
				end

				ST_CF_Y: begin
					y_q     <= prod_q[59:28];
					s_q     <= {1'b0, prod_q[59:28]};
					tn_q    <= 4'd2;
					ma_q    <= {1'b0, prod_q[59:28]};
					mb_q    <= {1'b0, prod_q[59:28]};
					ret_q   <= ST_CF_T;
					state_q <= ST_MUL_WAIT;
				end

				ST_CF_T: begin
					dq_q    <= {prod_q[63:32], 16'd0};
					dv_q    <= {29'd0, tn_q};
					r_q     <= '0;
					dcnt_q  <= 6'd32;
					ret_q   <= ST_CF_S;
					state_q <= ST_DIV_RUN;
				end

				// Add or subtract the next series term
				ST_CF_S: begin
					s_q <= s_n;
					if (tn_q == wtom_pkg::SERIES_LAST) begin
						state_q <= ST_CF_K;
					end else begin
						tn_q    <= tn_q + 4'd1;
						ma_q    <= {1'b0, term_n};
						mb_q    <= {1'b0, y_q};
						ret_q   <= ST_CF_T;
						state_q <= ST_MUL_WAIT;
					end
				end

				ST_CF_K: begin
					k_q     <= wtom_pkg::ONE_Q32 - (ex >> ip_q);
					state_q <= coef_ret_q;
				end

				// Scale the heat step
				ST_AX: begin
					ax_q    <= ax_n;
					ma_q    <= {17'd0, ax_opnd};
					mb_q    <= {17'd0, ax_n};
					ret_q   <= ST_ACC;
					state_q <= ST_MUL_WAIT;
				end

				ST_ACC: begin
					acc_q   <= acc_n;
					ma_q    <= {17'd0, acc_n[15:0]};
					mb_q    <= {17'd0, ax_q};
					ret_q   <= ST_FR;
					state_q <= ST_MUL_WAIT;
				end

				ST_FR: begin
					acc_q   <= acc_fr;
					state_q <= ST_CLAMP;
				end

				// Hold the integrator between nominal and one below the first table current
				ST_CLAMP: begin
					if (acc_q > bnd_hi) begin
						integ_q <= bnd_hi[31:0];
					end else if (acc_q < bnd_lo) begin
						integ_q <= bnd_lo[31:0];
					end else begin
						integ_q <= acc_q[31:0];
					end
					i_q     <= n_pts - NW'(1);
					state_q <= ST_LM_RD;
				end

				ST_LM_RD: begin
					state_q <= ST_LM_CHK;
				end

				ST_LM_CHK: begin
					ca_q       <= $signed({1'b0, rdata_q.cur}) - $signed({1'b0, imax});
					cb_q       <= $signed({1'b0, rdata_q.cur}) - $signed({4'd0, nom_q});
					ct_q       <= rdata_q.tim;
					coef_ret_q <= ST_LM_INV;
					state_q    <= ST_CF_START;
				end

				// Invert the last point's coefficient
				ST_LM_INV: begin
					if (k_q == '0) begin
						inv_q   <= 16'hffff;
						state_q <= ST_LM_M1;
					end else begin
						dq_q    <= {1'b1, 47'd0};
						dv_q    <= k_q;
						r_q     <= '0;
						dcnt_q  <= 6'd33;
						ret_q   <= ST_LM_INVD;
						state_q <= ST_DIV_RUN;
					end
				end

				ST_LM_INVD: begin
					inv_q   <= (dq_q[32:0] > 33'h0ffff) ? 16'hffff : dq_q[15:0];
					state_q <= ST_LM_M1;
				end

				ST_LM_M1: begin
					dneg_q  <= dl_s[16];
					ma_q    <= {17'd0, dl_mag};
					mb_q    <= {17'd0, inv_q};
					ret_q   <= ST_LM_M2;
					state_q <= ST_MUL_WAIT;
				end

				ST_LM_M2: begin
					acc_q   <= dneg_q ? -pq_s : pq_s;
					ma_q    <= {17'd0, integ_q[15:0]};
					mb_q    <= {17'd0, inv_q};
					ret_q   <= ST_LM_M3;
					state_q <= ST_MUL_WAIT;
				end

				// Saturate the current limit
				ST_LM_M3: begin
					if (lim_n > $signed({20'd0, capv})) begin
						lim_q <= capv;
					end else if (lim_n < 36'sd0) begin
						lim_q <= 16'd0;
					end else begin
						lim_q <= lim_n[15:0];
					end
					done_q  <= 1'b1;
					state_q <= ST_FIN;
				end

				ST_MUL_WAIT: begin
					state_q <= ret_q;
				end

				// Retire one quotient bit
				ST_DIV_RUN: begin
					r_q    <= rge ? rdiff[32:0] : rs[32:0];
					dq_q   <= {dq_q[46:0], rge};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						state_q <= ret_q;
					end
				end

				// Load the result word when the output register is free
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q.current_limit   <= lim_q;
						out_q.heat_level      <= integ_q[31:16];
						out_q.average_current <= avg_q;
						out_q.cycle_done      <= done_q;
						out_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/winding_thermal_overload_model_tb.sv
// Self-checking testbench of winding_thermal_overload_model: directed words, then random ones.
// A scoreboard class predicts every result word; plain tasks drive the input handshake.
// Depends on wtom_pkg and the block itself.
module winding_thermal_overload_model_tb;
	import wtom_pkg::*;

	localparam int NPTS = 8;
	localparam int WATCH_LIMIT = 40000;

	// Predicts result words and holds the ones still owed by the block
	class thermal_scoreboard;
		bit [31:0] nom, cool, npts, per;
		bit [31:0] msum, scount, avg, integ_r, limit_r;
		bit [31:0] tcur[NPTS], ttim[NPTS];
		out_word_t owed[$];
		int mismatches, checked, cycles_seen;

		function new();
			nom = 100; cool = 600; npts = 4; per = 1;
			msum = 0; scount = 0; avg = 0; integ_r = 0; limit_r = 0;
			foreach (tcur[i]) begin
				tcur[i] = 0;
				ttim[i] = 0;
			end
			mismatches = 0; checked = 0; cycles_seen = 0;
		endfunction

		function void set_reg(bit [1:0] idx, bit [15:0] val);
			case (idx)
				CFG_NOMINAL: nom = val & 16'h1fff;
				CFG_COOLING: cool = val;
				CFG_POINTS: npts = val & 16'hf;
				default: per = val;
			endcase
		endfunction

		// Base-2 logarithm in Q28
		function longint unsigned log2_q28(longint unsigned v);
			int unsigned msb;
			longint unsigned m, res;
			msb = 0;
			while (msb < 30 && (v >> (msb + 1)) != 0) msb++;
			m = v << (30 - msb);
			res = longint'(msb) << 28;
			for (int it = 0; it < 28; it++) begin
				m = (m * m) >> 30;
				if (m >= (64'd2 << 30)) begin
					m = m >> 1;
					res = res | (64'd1 << (27 - it));
				end
			end
			return res;
		endfunction

		// 1 - (a/b)^(p/t) in Q32
		function longint unsigned decay_coef(longint a, longint b, bit [31:0] t, bit [31:0] p);
			longint unsigned e, f, y, term, s, ex;
			int unsigned ip;
			if (b <= 0 || a >= b) return 0;
			if (a <= 0 || t == 0) return 64'h1_0000_0000;
			e = longint'(p) * (log2_q28(b) - log2_q28(a)) / longint'(t);
			if ((e >> 28) >= 40) return 64'h1_0000_0000;
			ip = e >> 28;
			f = e & 64'h0fff_ffff;
			y = (f * 64'd2977044472) >> 28;
			term = y;
			s = y;
			for (int n = 2; n <= 14; n++) begin
				term = ((term * y) >> 32) / n;
				if (n % 2 == 0) s = s - term;
				else s = s + term;
			end
			ex = 64'h1_0000_0000 - s;
			return 64'h1_0000_0000 - (ex >> ip);
		endfunction

		function bit [31:0] cap16(longint unsigned v);
			return (v >= 64'hffff) ? 32'hffff : v[31:0];
		endfunction

		// Close one calculation cycle: average, integrator, limit
		function void close_cycle();
			bit [31:0] n, ix, hi, bx, tm, ax, idx;
			longint imax, integ, lim, cap, dt, dx, dc;
			longint unsigned k, inv, fr;
			int i;
			if (scount != 0) avg = (msum + scount / 2) / scount;
			msum = 0; scount = 0;
			ix = avg;
			n = npts;
			if (n < 1) n = 1;
			if (n > NPTS) n = NPTS;
			imax = (tcur[0] + 32'hffff) & 32'hffff;
			integ = integ_r;
			hi = integ_r >> 16;
			if (ix >= hi) begin
				i = 0;
				while (i < n && ix >= tcur[i]) i++;
				if (i == 0) begin
					bx = tcur[0]; tm = ttim[0];
				end else if (i == n) begin
					bx = tcur[n-1]; tm = ttim[n-1];
				end else begin
					dt = longint'(ttim[i]) - longint'(ttim[i-1]);
					dx = longint'(ix) - longint'(tcur[i-1]);
					dc = longint'(tcur[i]) - longint'(tcur[i-1]);
					bx = ix;
					tm = longint'(ttim[i-1]) + dt * dx / dc;
				end
				k = decay_coef(longint'(bx) - imax, longint'(bx) - longint'(nom), tm, per);
				ax = cap16((k >> 8) + 1);
				integ = integ + longint'((longint'(ix - hi) * longint'(ax)) >> 8);
				fr = integ & 64'hffff;
				integ = integ - longint'((fr * ax) >> 24);
			end else begin
				bx = tcur[0];
				k = decay_coef(longint'(bx) - imax, longint'(bx) - longint'(nom), cool, per);
				ax = cap16(k >> 8);
				integ = integ - longint'((longint'(hi - ix) * longint'(ax)) >> 8);
				fr = integ & 64'hffff;
				integ = integ - longint'((fr * ax) >> 24);
			end
			if (integ > imax * 65536) integ = imax * 65536;
			else if (integ < longint'(nom) * 65536) integ = longint'(nom) * 65536;
			integ_r = integ[31:0];
			idx = n - 1;
			bx = tcur[idx];
			k = decay_coef(longint'(bx) - imax, longint'(bx) - longint'(nom), ttim[idx], per);
			inv = (k == 0) ? 64'hffff : 64'h1_0000_0000 / k;
			if (inv > 64'hffff) inv = 64'hffff;
			hi = integ_r >> 16;
			fr = integ_r & 32'hffff;
			lim = (imax - longint'(hi)) * longint'(inv) - longint'((fr * inv) >> 16)
				+ longint'(hi);
			cap = longint'(nom) * 10 - 1;
			if (cap > 65535) cap = 65535;
			if (cap < 0) cap = 0;
			if (lim > cap) lim = cap;
			if (lim < 0) lim = 0;
			limit_r = lim[31:0];
		endfunction

		// Note one accepted input word and queue the result it owes
		function void note_input(in_word_t w);
			out_word_t r;
			bit [31:0] v, mag, sum, l;
			bit done;
			done = 0;
			case (w.mode)
				MODE_TABLE: begin
					tcur[w.point_index] = w.point_current;
					ttim[w.point_index] = w.point_time;
				end
				MODE_RESTART: begin
					l = nom * 10;
					limit_r = (l > 32'hffff) ? 32'hffff : l;
					integ_r = ((tcur[0] + nom) / 2) << 16;
					msum = 0; scount = 0;
				end
				default: begin
					v = 32'(w.sample_current) & 32'hffff;
					mag = v[15] ? (32'h10000 - v) : v;
					sum = msum + mag;
					if (sum <= 32'hffff && scount < 32'hffff) begin
						msum = sum;
						scount++;
					end
					if (w.mode == MODE_CYCLE) begin
						close_cycle();
						done = 1;
						cycles_seen++;
					end
				end
			endcase
			r.current_limit = limit_r[15:0];
			r.heat_level = integ_r[31:16];
			r.average_current = avg[15:0];
			r.cycle_done = done;
			owed.push_back(r);
		endfunction

		// Compare one accepted result word with the oldest one owed
		function void check_result(out_word_t got);
			out_word_t exp_w;
			checked++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			exp_w = owed.pop_front();
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at word %0d: exp lim %0d heat %0d avg %0d done %0b, got lim %0d heat %0d avg %0d done %0b",
						checked, exp_w.current_limit, exp_w.heat_level,
						exp_w.average_current, exp_w.cycle_done, got.current_limit,
						got.heat_level, got.average_current, got.cycle_done);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_word_t in_data;
	out_word_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	thermal_scoreboard sb;
	int send_idle, recv_idle;
	int quiet_cycles;
	int words_sent;

	winding_thermal_overload_model uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = CFG_NOMINAL;
		cfg_data = 0;
		send_idle = 0;
		recv_idle = 0;
		quiet_cycles = 0;
		words_sent = 0;
		sb = new();
	end

	always #6 clk = ~clk;

	// Stall the receiver at random and check every accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watch for a stretch with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCH_LIMIT);
			$display("[winding_thermal_overload_model] ERROR");
			$finish;
		end
	end

	// Offer one word, hold it until taken, then maybe idle
	task send_word(input in_word_t w);
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
		words_sent++;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task send_mode(input logic [1:0] md, input logic [15:0] smp);
		in_word_t w;
		w = '0;
		w.mode = md;
		w.sample_current = smp;
		w.point_index = $urandom;
		w.point_current = $urandom;
		w.point_time = $urandom;
		send_word(w);
	endtask

	task send_point(input logic [2:0] idx, input logic [15:0] cur, input logic [15:0] tim);
		in_word_t w;
		w = '0;
		w.mode = MODE_TABLE;
		w.sample_current = $urandom;
		w.point_index = idx;
		w.point_current = cur;
		w.point_time = tim;
		send_word(w);
	endtask

	// Write a full increasing-current, decreasing-time table above nominal
	task load_table();
		int c, t;
		c = sb.nom + $urandom_range(300, 1);
		t = $urandom_range(65535, 2000);
		for (int i = 0; i < NPTS; i++) begin
			send_point(i, c, t);
			c = c + $urandom_range(3000, 1);
			if (c > 65535) c = 65535;
			t = t - $urandom_range(t / 3 + 1, 1);
			if (t < 0) t = 0;
		end
	endtask

	// Drain all owed words, then write every register while idle
	task set_config(input int nom, input int cool, input int pts, input int per);
		in_valid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= CFG_NOMINAL; cfg_data <= nom;
		@(posedge clk);
		sb.set_reg(CFG_NOMINAL, nom);
		cfg_index <= CFG_COOLING; cfg_data <= cool;
		@(posedge clk);
		sb.set_reg(CFG_COOLING, cool);
		cfg_index <= CFG_POINTS; cfg_data <= pts;
		@(posedge clk);
		sb.set_reg(CFG_POINTS, pts);
		cfg_index <= CFG_PERIOD; cfg_data <= per;
		@(posedge clk);
		sb.set_reg(CFG_PERIOD, per);
		cfg_we <= 0;
	endtask

	// Sample near the table range most of the time, anywhere otherwise
	function logic [15:0] pick_sample();
		int m;
		if ($urandom_range(3) == 0) return $urandom;
		m = sb.tcur[$urandom_range(NPTS - 1)] + $urandom_range(400) - 200;
		if (m < 0) m = 0;
		if (m > 32767) m = 32767;
		return $urandom_range(1) ? m[15:0] : -m[15:0];
	endfunction

	task random_run(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 66) send_mode(MODE_SAMPLE, pick_sample());
			else if (r < 84) send_mode(MODE_CYCLE, pick_sample());
			else if (r < 88) send_mode(MODE_RESTART, $urandom);
			else if (r < 93) send_point($urandom, $urandom, $urandom);
			else if (r < 96) load_table();
			else send_point(0, sb.tcur[0], sb.ttim[0] ^ 16'h1);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: full table, restart, field extremes, overflow, cooling, degenerate table
		send_idle = 34; recv_idle = 62;
		load_table();
		send_mode(MODE_RESTART, 16'h0);
		send_mode(MODE_SAMPLE, 16'h7fff);
		send_mode(MODE_SAMPLE, 16'h8000);
		send_mode(MODE_SAMPLE, 16'hffff);
		send_mode(MODE_CYCLE, 16'h0001);
		send_mode(MODE_CYCLE, 16'h0000);
		send_point(0, 16'h0000, 16'h0000);
		send_mode(MODE_CYCLE, 16'h0200);
		send_point(0, 16'hffff, 16'hffff);
		send_mode(MODE_RESTART, 16'h0);
		send_mode(MODE_CYCLE, 16'h7fff);
		load_table();
		send_mode(MODE_RESTART, 16'h0);
		random_run(280);

		set_config(1, 1, 2, 65535);
		send_idle = 62; recv_idle = 34;
		load_table();
		send_mode(MODE_RESTART, 16'h0);
		random_run(280);

		set_config(6553, 65535, 8, 1);
		send_idle = 0; recv_idle = 0;
		load_table();
		send_mode(MODE_RESTART, 16'h0);
		random_run(280);

		set_config($urandom_range(6553, 1), $urandom_range(65535, 1), $urandom_range(8, 2),
			$urandom_range(65535, 1));
		send_idle = 34; recv_idle = 62;
		load_table();
		send_mode(MODE_RESTART, 16'h0);
		random_run(280);

		in_valid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d input words, %0d cycle ends, %0d results checked, four settings",
			words_sent, sb.cycles_seen, sb.checked);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("[winding_thermal_overload_model] OK");
		else
			$display("[winding_thermal_overload_model] ERROR");
		$finish;
	end
endmodule

### files.f
rtl/wtom_pkg.sv
rtl/winding_thermal_overload_model.sv
tb/winding_thermal_overload_model_tb.sv
